// ----- hdl/dpsv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsv_pkg
// Shared types and constants for the decaying band-limited square voice.
// ----------------------------------------------------------------------------
package dpsv_pkg;

  // fixed-point constants
  localparam logic [15:0] FADE_RESET     = 16'd45875;   // 0.7 in Q0.16
  localparam logic [17:0] BEND_ONE       = 18'd65536;   // 1.0 in Q2.16
  localparam logic [31:0] HALF_CYCLE     = 32'h8000_0000;
  localparam logic [31:0] LOW_FREQ_LIMIT = 32'd21475;   // 0.16 Hz at 32 kHz
  localparam logic [15:0] GAIN_Q16       = 16'd52429;   // 0.8 in Q0.16
  localparam logic [17:0] UNIT_Q14       = 18'd16384;   // 1.0 in Q4.14
  localparam logic [16:0] ONE_Q16        = 17'd65536;

  // shared multiplier operand widths
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // edge divider quotient width
  localparam int DIV_Q_W = 16;

  // configuration address map
  localparam int          CFG_ADDR_W    = 3;
  localparam logic        REG_FADE_IDX  = 1'b0;

  // input actions
  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_TRIGGER = 1'b1;

  typedef struct packed {
    logic        action;
    logic [16:0] amplitude;
    logic [31:0] frequency;
    logic [17:0] bend;
  } dpsv_in_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } dpsv_out_t;

  // divider result back to the sequencer
  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quo;
  } dpsv_div_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AMP_MUL,
    ST_AMP_WB,
    ST_FREQ_MUL,
    ST_FREQ_WB,
    ST_EDGE,
    ST_DIV,
    ST_SQ_MUL,
    ST_SQ_WB,
    ST_MAG_MUL,
    ST_GAIN_MUL,
    ST_GAIN_WB,
    ST_DONE
  } dpsv_state_t;

endpackage

// ----- hdl/dpsv_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsv_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module dpsv_mul (
  input  logic                         clk,
  input  logic [dpsv_pkg::MUL_A_W-1:0] a,
  input  logic [dpsv_pkg::MUL_B_W-1:0] b,
  output logic [dpsv_pkg::MUL_P_W-1:0] p
);

  logic [dpsv_pkg::MUL_P_W-1:0] p_r;
  logic [dpsv_pkg::MUL_P_W-1:0] p_nxt;

  // product of the operands the sequencer presents
  assign p_nxt = {{dpsv_pkg::MUL_B_W{1'b0}}, a} * {{dpsv_pkg::MUL_A_W{1'b0}}, b};

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  assign p = p_r;

endmodule

// ----- hdl/dpsv_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsv_div
// Restoring divider, one quotient bit per cycle: (num << 16) / den, num < den.
// ----------------------------------------------------------------------------
module dpsv_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [31:0]             num,
  input  logic [31:0]             den,
  output dpsv_pkg::dpsv_div_res_t res
);

  logic [31:0]                    rem_r, rem_nxt;
  logic [31:0]                    den_r, den_nxt;
  logic [dpsv_pkg::DIV_Q_W-1:0]   quo_r, quo_nxt;
  logic [4:0]                     cnt_r, cnt_nxt;
  logic                           done_r, done_nxt;
  logic [32:0]                    rem2;
  logic [32:0]                    diff;
  logic                           ge;

  // one trial subtraction per step
  always_comb begin
    rem2     = {rem_r, 1'b0};
    diff     = rem2 - {1'b0, den_r};
    ge       = (rem2 >= {1'b0, den_r});
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = num;
      den_nxt = den;
      quo_nxt = '0;
      cnt_nxt = 5'(dpsv_pkg::DIV_Q_W);
    end else if (cnt_r != 5'd0) begin
      rem_nxt  = ge ? diff[31:0] : rem2[31:0];
      quo_nxt  = {quo_r[dpsv_pkg::DIV_Q_W-2:0], ge};
      cnt_nxt  = cnt_r - 5'd1;
      done_nxt = (cnt_r == 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 5'd0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;

endmodule

// ----- hdl/decaying_polyblep_square_voice_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decaying_polyblep_square_voice_top
// One band-limited square voice with amplitude fade and frequency glide.
// ----------------------------------------------------------------------------
// A trigger transfer loads amplitude, frequency and bend together and
// gives no result. A tick transfer runs a sequencer over one shared
// multiplier and a bit-serial divider: fade and bend multiplies, phase
// advance, then for each of the two square edges that lies within one
// increment of the phase a division and a squaring, then the gain
// multiplies, plus any wait for a stalled result to leave. in_stall is
// high throughout, so the next transfer follows only once the tick's
// result is in the output register. The result waits there, and a new
// transfer is taken while it waits. fade_factor sits at byte address 0
// of the APB port.
// ----------------------------------------------------------------------------
module decaying_polyblep_square_voice_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  dpsv_pkg::dpsv_in_t                  in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output dpsv_pkg::dpsv_out_t                 out_data,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dpsv_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  dpsv_pkg::dpsv_state_t           state_r, state_nxt;

  logic [15:0]                     fade_r, fade_nxt;
  logic [31:0]                     phase_r, phase_nxt;
  logic [31:0]                     freq_r, freq_nxt;
  logic [16:0]                     amp_r, amp_nxt;
  logic [17:0]                     bend_r, bend_nxt;
  logic signed [17:0]              s_r, s_nxt;
  logic                            e_r, e_nxt;
  logic                            neg_r, neg_nxt;
  logic [15:0]                     sample_r, sample_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [15:0]                     out_r, out_nxt;

  logic [dpsv_pkg::MUL_A_W-1:0]    mul_a;
  logic [dpsv_pkg::MUL_B_W-1:0]    mul_b;
  logic [dpsv_pkg::MUL_P_W-1:0]    mul_p;

  logic                            div_start;
  logic [31:0]                     div_num;
  dpsv_pkg::dpsv_div_res_t         div_res;

  logic                            in_xfer;
  logic                            cfg_wr;
  logic                            out_free;
  logic [33:0]                     freq_prod;
  logic [31:0]                     freq_new;
  logic [31:0]                     edge_x;
  logic [32:0]                     edge_sum;
  logic                            edge_rise;
  logic                            edge_fall;
  logic [16:0]                     sq_in;
  logic [15:0]                     sq;
  logic signed [17:0]              sq_ext;
  logic signed [17:0]              s_neg;
  logic [16:0]                     mag;
  logic [49:0]                     rnd;
  logic [17:0]                     res;
  logic [17:0]                     res_neg;

  // shared arithmetic
  dpsv_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  dpsv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (freq_r),
    .res   (div_res)
  );

  // handshakes
  assign in_stall  = (state_r != dpsv_pkg::ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == dpsv_pkg::REG_FADE_IDX) ? {16'd0, fade_r} : 32'd0;

  // edge tests for the current edge: the other edge lies half the phase range on
  assign edge_x    = phase_r ^ dpsv_pkg::HALF_CYCLE & {e_r, 31'd0};
  assign edge_sum  = {1'b0, edge_x} + {1'b0, freq_r};
  assign edge_rise = (edge_x < freq_r);
  assign edge_fall = edge_sum[32] && (edge_sum[31:0] != 32'd0);
  assign div_num   = edge_rise ? edge_x : edge_sum[31:0];

  // bend applied to frequency, saturated just below one cycle per sample
  assign freq_prod = mul_p[49:16];
  assign freq_new  = (freq_prod[33:32] != 2'b00) ? 32'hFFFF_FFFF : freq_prod[31:0];

  // edge correction squaring and accumulation
  assign sq_in  = neg_r ? (dpsv_pkg::ONE_Q16 - {1'b0, div_res.quo}) : {1'b0, div_res.quo};
  assign sq     = mul_p[33:18];
  assign sq_ext = $signed({2'b00, sq});

  // magnitude and rounded gain
  assign s_neg   = -s_r;
  assign mag     = s_r[17] ? s_neg[16:0] : s_r[16:0];
  assign rnd     = mul_p[49:0] + 50'h0_8000_0000;
  assign res     = rnd[49:32];
  assign res_neg = 18'd0 - res;

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      dpsv_pkg::ST_AMP_MUL: begin
        mul_a = {17'd0, amp_r};
        mul_b = {2'd0, fade_r};
      end
      dpsv_pkg::ST_FREQ_MUL: begin
        mul_a = {2'd0, freq_r};
        mul_b = bend_r;
      end
      dpsv_pkg::ST_SQ_MUL: begin
        mul_a = {17'd0, sq_in};
        mul_b = {1'b0, sq_in};
      end
      dpsv_pkg::ST_MAG_MUL: begin
        mul_a = {17'd0, mag};
        mul_b = {1'b0, amp_r};
      end
      dpsv_pkg::ST_GAIN_MUL: begin
        mul_a = mul_p[33:0];
        mul_b = {2'd0, dpsv_pkg::GAIN_Q16};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    fade_nxt      = fade_r;
    phase_nxt     = phase_r;
    freq_nxt      = freq_r;
    amp_nxt       = amp_r;
    bend_nxt      = bend_r;
    s_nxt         = s_r;
    e_nxt         = e_r;
    neg_nxt       = neg_r;
    sample_nxt    = sample_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    div_start     = 1'b0;

    // result register drains independently of the sequencer
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr && (paddr[2] == dpsv_pkg::REG_FADE_IDX)) begin
      fade_nxt = pwdata[15:0];
    end

    case (state_r)
      dpsv_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_data.action == dpsv_pkg::ACT_TRIGGER) begin
            amp_nxt  = in_data.amplitude;
            freq_nxt = in_data.frequency;
            bend_nxt = in_data.bend;
          end else begin
            state_nxt = dpsv_pkg::ST_AMP_MUL;
          end
        end
      end
      dpsv_pkg::ST_AMP_MUL: begin
        state_nxt = dpsv_pkg::ST_AMP_WB;
      end
      dpsv_pkg::ST_AMP_WB: begin
        amp_nxt   = mul_p[32:16];
        state_nxt = dpsv_pkg::ST_FREQ_MUL;
      end
      dpsv_pkg::ST_FREQ_MUL: begin
        state_nxt = dpsv_pkg::ST_FREQ_WB;
      end
      dpsv_pkg::ST_FREQ_WB: begin
        // glide limits, phase advance and square level
        freq_nxt = freq_new;
        if ((freq_new > dpsv_pkg::HALF_CYCLE) && (bend_r > dpsv_pkg::BEND_ONE)) begin
          bend_nxt = dpsv_pkg::BEND_ONE;
        end
        if ((freq_new < dpsv_pkg::LOW_FREQ_LIMIT) && (bend_r < dpsv_pkg::BEND_ONE)) begin
          bend_nxt = dpsv_pkg::BEND_ONE;
        end
        phase_nxt = phase_r + freq_new;
        s_nxt     = phase_nxt[31] ? -$signed(dpsv_pkg::UNIT_Q14)
                                  : $signed(dpsv_pkg::UNIT_Q14);
        e_nxt     = 1'b0;
        state_nxt = dpsv_pkg::ST_EDGE;
      end
      dpsv_pkg::ST_EDGE: begin
        if (edge_rise || edge_fall) begin
          neg_nxt   = edge_rise;
          div_start = 1'b1;
          state_nxt = dpsv_pkg::ST_DIV;
        end else if (e_r) begin
          state_nxt = dpsv_pkg::ST_MAG_MUL;
        end else begin
          e_nxt = 1'b1;
        end
      end
      dpsv_pkg::ST_DIV: begin
        if (div_res.done) begin
          state_nxt = dpsv_pkg::ST_SQ_MUL;
        end
      end
      dpsv_pkg::ST_SQ_MUL: begin
        state_nxt = dpsv_pkg::ST_SQ_WB;
      end
      dpsv_pkg::ST_SQ_WB: begin
        // rising side correction is negative; on the half-period edge (e_r set) the sign is inverted
        if (neg_r ^ e_r) begin
          s_nxt = s_r - sq_ext;
        end else begin
          s_nxt = s_r + sq_ext;
        end
        if (e_r) begin
          state_nxt = dpsv_pkg::ST_MAG_MUL;
        end else begin
          e_nxt     = 1'b1;
          state_nxt = dpsv_pkg::ST_EDGE;
        end
      end
      dpsv_pkg::ST_MAG_MUL: begin
        state_nxt = dpsv_pkg::ST_GAIN_MUL;
      end
      dpsv_pkg::ST_GAIN_MUL: begin
        state_nxt = dpsv_pkg::ST_GAIN_WB;
      end
      dpsv_pkg::ST_GAIN_WB: begin
        // sign restore with saturation
        if (s_r[17]) begin
          sample_nxt = (res > 18'd32768) ? 16'h8000 : res_neg[15:0];
        end else begin
          sample_nxt = (res > 18'd32767) ? 16'h7FFF : res[15:0];
        end
        state_nxt = dpsv_pkg::ST_DONE;
      end
      dpsv_pkg::ST_DONE: begin
        if (out_free) begin
          out_nxt       = sample_r;
          out_valid_nxt = 1'b1;
          state_nxt     = dpsv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dpsv_pkg::ST_IDLE;
      end
    endcase
  end

  // control and voice state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dpsv_pkg::ST_IDLE;
      fade_r      <= dpsv_pkg::FADE_RESET;
      phase_r     <= 32'd0;
      freq_r      <= 32'd0;
      amp_r       <= 17'd0;
      bend_r      <= dpsv_pkg::BEND_ONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fade_r      <= fade_nxt;
      phase_r     <= phase_nxt;
      freq_r      <= freq_nxt;
      amp_r       <= amp_nxt;
      bend_r      <= bend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    s_r      <= s_nxt;
    e_r      <= e_nxt;
    neg_r    <= neg_nxt;
    sample_r <= sample_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_data.left_sample  = $signed(out_r);
  assign out_data.right_sample = $signed(out_r);

endmodule
